// ===== rtl/ssp_pkg.sv =====
// shared constants, codes and controller/datapath interface types
`default_nettype none
package ssp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CAPACITY   = 64;
  // count holds 0..CAPACITY
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // sum of three counts
  localparam int SUM_W  = CNT_W + 2;

  // which source a result comes from
  localparam logic [1:0] SRC_POS  = 2'd0;
  localparam logic [1:0] SRC_ZERO = 2'd1;
  localparam logic [1:0] SRC_NEG  = 2'd2;

  typedef struct packed {
    logic       load;         // input word accepted this cycle
    logic       issue;        // start one result down the read pipe
    logic [1:0] src;          // phase being issued
    logic       idx_clear;    // restart the issue index
    logic       batch_clear;  // clear counts and drop flag
  } ssp_cmd_t;

  typedef struct packed {
    logic advance;    // read pipe may move this cycle
    logic idx_done;   // current index is the final one of its phase
    logic pos_nz;
    logic zero_nz;
    logic neg_nz;
    logic pipe_empty; // nothing left in read pipe or output register
  } ssp_status_t;

endpackage
`default_nettype wire

// ===== rtl/ssp_ctrl.sv =====
// controller: load, emit phases and drain sequencing
`default_nettype none
module ssp_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  last,
  output logic                 in_stall,
  input  wire ssp_pkg::ssp_status_t status,
  output ssp_pkg::ssp_cmd_t    cmd
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_POS   = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_NEG   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       emitting;
  logic       phase_end;

  assign in_stall  = (state != ST_LOAD);
  assign emitting  = (state == ST_POS) || (state == ST_ZERO) || (state == ST_NEG);
  assign phase_end = emitting && status.advance && status.idx_done;

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == ST_LOAD) && in_valid;
    cmd.issue       = emitting && status.advance;
    cmd.idx_clear   = (state == ST_START) || phase_end;
    cmd.batch_clear = (state == ST_DRAIN) && status.pipe_empty;
    unique case (state)
      ST_ZERO: cmd.src = ssp_pkg::SRC_ZERO;
      ST_NEG:  cmd.src = ssp_pkg::SRC_NEG;
      default: cmd.src = ssp_pkg::SRC_POS;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && last) state_next = ST_START;
      end
      ST_START: begin
        if (status.pos_nz)       state_next = ST_POS;
        else if (status.zero_nz) state_next = ST_ZERO;
        else if (status.neg_nz)  state_next = ST_NEG;
        else                     state_next = ST_DRAIN;
      end
      ST_POS: begin
        if (phase_end) begin
          if (status.zero_nz)     state_next = ST_ZERO;
          else if (status.neg_nz) state_next = ST_NEG;
          else                    state_next = ST_DRAIN;
        end
      end
      ST_ZERO: begin
        if (phase_end) begin
          if (status.neg_nz) state_next = ST_NEG;
          else               state_next = ST_DRAIN;
        end
      end
      ST_NEG: begin
        if (phase_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.pipe_empty) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

// ===== rtl/ssp_datapath.sv =====
// datapath: sign stores, counts, read pipe and output register
`default_nettype none
module ssp_datapath (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire signed [ssp_pkg::DATA_WIDTH-1:0]    value,
  input  wire ssp_pkg::ssp_cmd_t                  cmd,
  output ssp_pkg::ssp_status_t                    status,
  input  wire                                     out_stall,
  output logic                                    out_valid,
  output logic signed [ssp_pkg::DATA_WIDTH-1:0]   result_value,
  output logic                                    result_last,
  output logic                                    overflowed
);

  logic [ssp_pkg::DATA_WIDTH-1:0] pos_mem [ssp_pkg::CAPACITY];
  logic [ssp_pkg::DATA_WIDTH-1:0] neg_mem [ssp_pkg::CAPACITY];

  logic [ssp_pkg::CNT_W-1:0] pos_count;
  logic [ssp_pkg::CNT_W-1:0] neg_count;
  logic [ssp_pkg::CNT_W-1:0] zero_count;
  logic                      drop_flag;
  logic [ssp_pkg::CNT_W-1:0] idx;

  logic [ssp_pkg::SUM_W-1:0] total;
  logic                      full;
  logic                      in_zero;
  logic                      in_neg;
  logic [ssp_pkg::CNT_W-1:0] phase_count;
  logic                      issue_last;
  logic                      advance;

  // read stage
  logic                           rd_valid;
  logic [1:0]                     rd_src;
  logic                           rd_last;
  logic [ssp_pkg::DATA_WIDTH-1:0] pos_rd;
  logic [ssp_pkg::DATA_WIDTH-1:0] neg_rd;
  logic [ssp_pkg::DATA_WIDTH-1:0] rd_value;

  assign total = ssp_pkg::SUM_W'(pos_count) + ssp_pkg::SUM_W'(neg_count)
               + ssp_pkg::SUM_W'(zero_count);
  assign full    = (total >= ssp_pkg::SUM_W'(ssp_pkg::CAPACITY));
  assign in_zero = (value == '0);
  assign in_neg  = value[ssp_pkg::DATA_WIDTH-1];
  assign advance = !out_valid || !out_stall;

  always_comb begin
    case (cmd.src)
      ssp_pkg::SRC_ZERO: phase_count = zero_count;
      ssp_pkg::SRC_NEG:  phase_count = neg_count;
      default:           phase_count = pos_count;
    endcase
  end

  always_comb begin
    status            = '0;
    status.advance    = advance;
    status.idx_done   = ({1'b0, idx} + 1'b1) == {1'b0, phase_count};
    status.pos_nz     = (pos_count != '0);
    status.zero_nz    = (zero_count != '0);
    status.neg_nz     = (neg_count != '0);
    status.pipe_empty = !rd_valid && !out_valid;
  end

  // final result of the batch: end of this phase with every later phase empty
  always_comb begin
    case (cmd.src)
      ssp_pkg::SRC_POS:  issue_last = status.idx_done && !status.zero_nz && !status.neg_nz;
      ssp_pkg::SRC_ZERO: issue_last = status.idx_done && !status.neg_nz;
      default:           issue_last = status.idx_done;
    endcase
  end

  // counts and drop flag
  always_ff @(posedge clk) begin
    if (rst || cmd.batch_clear) begin
      pos_count  <= '0;
      neg_count  <= '0;
      zero_count <= '0;
      drop_flag  <= 1'b0;
    end else if (cmd.load) begin
      if (full)         drop_flag  <= 1'b1;
      else if (in_zero) zero_count <= zero_count + 1'b1;
      else if (in_neg)  neg_count  <= neg_count + 1'b1;
      else              pos_count  <= pos_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full && !in_zero && !in_neg)
      pos_mem[pos_count[ssp_pkg::ADDR_W-1:0]] <= value;
    if (advance)
      pos_rd <= pos_mem[idx[ssp_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full && !in_zero && in_neg)
      neg_mem[neg_count[ssp_pkg::ADDR_W-1:0]] <= value;
    if (advance)
      neg_rd <= neg_mem[idx[ssp_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clear) idx <= '0;
    else if (cmd.issue)       idx <= idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else if (advance) rd_valid <= cmd.issue;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_src  <= cmd.src;
      rd_last <= issue_last;
    end
  end

  always_comb begin
    case (rd_src)
      ssp_pkg::SRC_POS: rd_value = pos_rd;
      ssp_pkg::SRC_NEG: rd_value = neg_rd;
      default:          rd_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= rd_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_value <= rd_value;
      result_last  <= rd_last;
      overflowed   <= drop_flag;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stable_sign_partition_unit.sv =====
// top level of the stable sign partition unit
`default_nettype none
// Stable three-way partition of a batch of signed words by sign. Input words
// are taken one per cycle while the unit is loading; a positive word is kept
// in the positive store, a negative one in the negative store (each in arrival
// order) and a zero is only counted. Up to CAPACITY words are held per batch;
// any further word is dropped and the batch is flagged as overflowed. After
// the word marked last is taken the unit stalls its input and emits every
// positive, then one zero per zero seen, then every negative, one result word
// per cycle when the output is not stalled, with result_last on the final one
// and overflowed on all of them if any word was dropped. The first result word
// passes through the sequencer start state, the registered store read and the
// output register. Once the final result word has been taken and the output
// register has emptied, the sequencer returns to loading and the input opens
// again. Emit speed is set by the single read port of each store.
module stable_sign_partition_unit (
  input  wire                                   clk,
  input  wire                                   rst,
  // input words
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire signed [ssp_pkg::DATA_WIDTH-1:0]  value,
  input  wire                                   last,
  // result words
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [ssp_pkg::DATA_WIDTH-1:0] result_value,
  output logic                                  result_last,
  output logic                                  overflowed
);

  ssp_pkg::ssp_cmd_t    cmd;
  ssp_pkg::ssp_status_t status;

  // sequencing: load, pick phase, emit phases, drain
  ssp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // stores, counters and the emit pipe
  ssp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .result_value (result_value),
    .result_last  (result_last),
    .overflowed   (overflowed)
  );

endmodule
`default_nettype wire

// ===== rtl/ssp_checker.sv =====
// port-level checks for the stable sign partition unit, with bind
`default_nettype none
module ssp_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire                           last,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire [ssp_pkg::DATA_WIDTH-1:0] result_value,
  input wire                           result_last,
  input wire                           overflowed
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value)
      && $stable(result_last) && $stable(overflowed))
    else $error("stalled result word changed");

  // input is never open while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input open while results pending");

  // last input word closes the input
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("input still open after last word");

  // overflow flag constant within a batch
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_last ##1 out_valid |-> $stable(overflowed))
    else $error("overflowed changed within a batch");

endmodule

bind stable_sign_partition_unit ssp_checker u_ssp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last         (last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_value (result_value),
  .result_last  (result_last),
  .overflowed   (overflowed)
);
`default_nettype wire

// ===== bench/stable_sign_partition_unit_test.sv =====
// self-checking testbench for the stable sign partition unit
module stable_sign_partition_unit_test;
  import ssp_pkg::*;

  // time units before the run is abandoned, well above the slowest correct run
  localparam int RUN_LIMIT   = 2_000_000;
  localparam int WORD_TARGET = 380;
  // cycles to watch after the final result word for anything stray
  localparam int TAIL_CYCLES = 20;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  localparam word_t TOP_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t TOP_NEG  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t ALL_ONES = '1;
  localparam word_t UNIT     = word_t'(1);
  localparam word_t NIL      = '0;

  // an input word plus the idle cycles the driver leaves before offering it
  typedef struct {
    word_t data;
    logic  fin;
    int    gap;
  } in_word_t;

  // one partitioned result word as the unit should present it
  typedef struct {
    word_t data;
    logic  fin;
    logic  ovf;
  } out_word_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t value = '0;
  logic  last = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t result_value;
  logic  result_last;
  logic  overflowed;

  stable_sign_partition_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .result_last  (result_last),
    .overflowed   (overflowed)
  );

  // words waiting to be offered, filled up front by the stimulus block
  in_word_t  pending_q[$];
  // partitioned words still owed by the unit, oldest first
  out_word_t partitioned_q[$];

  // predictor state: the two side stores, the counts and the sticky drop flag
  word_t pos_held[CAPACITY];
  word_t neg_held[CAPACITY];
  int    pos_n   = 0;
  int    neg_n   = 0;
  int    zero_n  = 0;
  logic  dropped = 1'b0;

  int words_queued   = 0;
  int words_sent     = 0;
  int batches_done   = 0;
  int overflow_seen  = 0;
  int results_checked = 0;
  int faults         = 0;
  int stall_left     = 0;

  initial forever #5 clk = ~clk;

  // gap length: mostly none or short, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 25);
  endfunction

  // zeros and the sign extremes turn up often, the rest is full-width noise
  function automatic word_t random_word();
    case ($urandom_range(0, 19))
      0, 1, 2: return NIL;
      3:       return TOP_POS;
      4:       return TOP_NEG;
      5:       return ALL_ONES;
      6:       return UNIT;
      default: return word_t'({$urandom(), $urandom()});
    endcase
  endfunction

  task automatic queue_word(input word_t data, input logic fin, input bit calm);
    in_word_t w;
    w.data = data;
    w.fin  = fin;
    w.gap  = calm ? 0 : idle_cycles();
    pending_q.push_back(w);
    words_queued++;
  endtask

  task automatic queue_batch(input int len, input bit calm);
    for (int i = 0; i < len; i++) queue_word(random_word(), i == len - 1, calm);
  endtask

  // take one accepted word into the side stores; on the final word of a batch
  // lay out positives, then zeros, then negatives, and start a fresh batch
  task automatic partition_word(input word_t w, input logic fin);
    int held;
    int k;
    held = pos_n + neg_n + zero_n;
    // store full: the word is lost and the whole batch is flagged
    if (held >= CAPACITY) begin
      dropped = 1'b1;
    end else if (w == NIL) begin
      zero_n++;
    end else if (w[DATA_WIDTH-1]) begin
      neg_held[neg_n] = w;
      neg_n++;
    end else begin
      pos_held[pos_n] = w;
      pos_n++;
    end
    if (fin) begin
      held = pos_n + zero_n + neg_n;
      k = 0;
      for (int i = 0; i < pos_n; i++) begin
        partitioned_q.push_back('{pos_held[i], k + 1 == held, dropped});
        k++;
      end
      for (int i = 0; i < zero_n; i++) begin
        partitioned_q.push_back('{NIL, k + 1 == held, dropped});
        k++;
      end
      for (int i = 0; i < neg_n; i++) begin
        partitioned_q.push_back('{neg_held[i], k + 1 == held, dropped});
        k++;
      end
      if (dropped) overflow_seen++;
      batches_done++;
      pos_n   = 0;
      neg_n   = 0;
      zero_n  = 0;
      dropped = 1'b0;
    end
  endtask

  // input driver: holds a word until it is taken, then either idles for the
  // next word's gap or offers it straight away
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_q[0].gap > 0) begin
        pending_q[0].gap = pending_q[0].gap - 1;
        in_valid <= 1'b0;
      end else begin
        value    <= pending_q[0].data;
        last     <= pending_q[0].fin;
        in_valid <= 1'b1;
        pending_q.pop_front();
        words_sent++;
      end
    end
  end

  // output back-pressure: runs of stall and of free flow, a few of each long
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_left = idle_cycles();
    end else begin
      out_stall  <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
    end
  end

  // monitor: both handshakes are sampled with the values held before the edge
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (in_valid && !in_stall) partition_word(value, last);
      if (out_valid && !out_stall) begin
        if (partitioned_q.size() == 0) begin
          $display("%0t: result word %h with nothing owed", $time, result_value);
          faults++;
        end else begin
          want = partitioned_q.pop_front();
          if (result_value !== want.data) begin
            $display("%0t: result_value expected %h got %h", $time, want.data, result_value);
            faults++;
          end
          if (result_last !== want.fin) begin
            $display("%0t: result_last expected %b got %b", $time, want.fin, result_last);
            faults++;
          end
          if (overflowed !== want.ovf) begin
            $display("%0t: overflowed expected %b got %b", $time, want.ovf, overflowed);
            faults++;
          end
          results_checked++;
        end
      end
    end
  end

  initial begin
    int len;
    bit calm;

    // single-word batches at the sign extremes and around zero
    queue_word(TOP_POS, 1'b1, 1'b0);
    queue_word(TOP_NEG, 1'b1, 1'b0);
    queue_word(NIL, 1'b1, 1'b0);
    queue_word(ALL_ONES, 1'b1, 1'b0);
    queue_word(UNIT, 1'b1, 1'b1);
    // mixed batch, order within each sign must be kept
    queue_word(word_t'(5), 1'b0, 1'b1);
    queue_word(NIL, 1'b0, 1'b1);
    queue_word(-word_t'(3), 1'b0, 1'b0);
    queue_word(TOP_POS, 1'b0, 1'b0);
    queue_word(TOP_NEG, 1'b0, 1'b1);
    queue_word(NIL, 1'b0, 1'b0);
    queue_word(word_t'(7), 1'b0, 1'b0);
    queue_word(ALL_ONES, 1'b0, 1'b0);
    queue_word(UNIT, 1'b1, 1'b0);
    // zeros only, negatives only, alternating bit patterns
    queue_word(NIL, 1'b0, 1'b1);
    queue_word(NIL, 1'b0, 1'b1);
    queue_word(NIL, 1'b1, 1'b1);
    queue_word(-word_t'(5), 1'b0, 1'b0);
    queue_word(-word_t'(6), 1'b1, 1'b0);
    queue_word({(DATA_WIDTH/2){2'b01}}, 1'b0, 1'b0);
    queue_word({(DATA_WIDTH/2){2'b10}}, 1'b1, 1'b0);

    // store filled exactly, then overrun so that the final three words are dropped
    queue_batch(CAPACITY, 1'b0);
    queue_batch(CAPACITY + 3, 1'b1);
    // mostly short batches, now and then one near or past capacity
    while (words_queued < WORD_TARGET) begin
      if ($urandom_range(0, 99) < 4) len = $urandom_range(CAPACITY - 2, CAPACITY + 4);
      else len = $urandom_range(1, 12);
      calm = ($urandom_range(0, 3) == 0);
      queue_batch(len, calm);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (partitioned_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words sent in %0d batches, %0d batches overran the store",
             words_sent, batches_done, overflow_seen);
    $display("%0d result words checked, %0d mismatches", results_checked, faults);
    if (faults == 0) begin
      $display("stable_sign_partition_unit_test: PASS");
    end else begin
      $display("stable_sign_partition_unit_test: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #RUN_LIMIT;
    $display("stable_sign_partition_unit_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssp_pkg.sv
rtl/ssp_ctrl.sv
rtl/ssp_datapath.sv
rtl/stable_sign_partition_unit.sv
rtl/ssp_checker.sv
bench/stable_sign_partition_unit_test.sv
